// ===== src/largest_first_greedy_thread_assign_defines.svh =====
// assertion macros for the largest-first greedy assignment block
`ifndef LARGEST_FIRST_GREEDY_THREAD_ASSIGN_DEFINES_SVH
`define LARGEST_FIRST_GREEDY_THREAD_ASSIGN_DEFINES_SVH

// same-cycle implication, off during reset
`define LFGTA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define LFGTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lfgta_pkg.sv =====
// types and constants shared by the largest-first greedy assignment block
`default_nettype none

package lfgta_pkg;

  localparam int unsigned MaxGroups   = 64;
  localparam int unsigned MaxWorkers  = 16;
  localparam int unsigned SizeW       = 10;
  localparam int unsigned LoadW       = 16;
  localparam int unsigned GroupIdxW   = $clog2(MaxGroups);
  localparam int unsigned WorkerIdxW  = $clog2(MaxWorkers);
  localparam int unsigned CountW      = GroupIdxW + 1;
  localparam int unsigned WorkerCntW  = 5;
  localparam int unsigned ActiveW     = WorkerIdxW + 1;
  localparam int unsigned BalanceMul  = 2;
  localparam int unsigned WorkMul     = 3;
  localparam int unsigned RamW        = SizeW + 1;

  typedef struct packed {
    logic [SizeW-1:0] group_size;
    logic             final_group;
  } in_t;

  typedef struct packed {
    logic [GroupIdxW-1:0]  group_index;
    logic [WorkerIdxW-1:0] worker_index;
    logic [LoadW-1:0]      worker_load_after;
    logic                  parallel_worthwhile;
    logic                  final_result;
  } out_t;

  typedef enum logic [2:0] {
    StLoad,
    StScan,
    StDrain,
    StWork,
    StEmit,
    StCheck,
    StLast
  } state_e;

endpackage

`default_nettype wire

// ===== src/lfgta_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module lfgta_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/largest_first_greedy_thread_assign.sv =====
// largest-first greedy cluster-to-worker assignment, top level
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+------------------------
//   in       | input     | in_valid_i / in_stall_o | lfgta_pkg::in_t
//   out      | output    | out_valid_o / out_stall_i | lfgta_pkg::out_t
//   cfg      | input     | cfg_we_i               | worker count, 5 bits
//
// loading takes one cluster per cycle while in_stall_o is low; a final
// cluster starts assignment, in which each cluster takes a size ram scan,
// a load scan and an emit step, then a check of the worker loads and one
// more emit step give the last result
// in_stall_o is high from the final cluster until the last result is registered
// out_stall_i holds both emit steps; reset clears control state and loads
`default_nettype none

`include "largest_first_greedy_thread_assign_defines.svh"

module largest_first_greedy_thread_assign (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire lfgta_pkg::in_t                       in_data_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output lfgta_pkg::out_t                           out_data_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [lfgta_pkg::WorkerCntW-1:0]     cfg_wdata_i
);

  localparam int unsigned GW = lfgta_pkg::GroupIdxW;
  localparam int unsigned WW = lfgta_pkg::WorkerIdxW;
  localparam int unsigned CW = lfgta_pkg::CountW;
  localparam int unsigned LW = lfgta_pkg::LoadW;
  localparam int unsigned SW = lfgta_pkg::SizeW;
  localparam int unsigned AW = lfgta_pkg::ActiveW;
  localparam int unsigned KW = lfgta_pkg::WorkerCntW;

  lfgta_pkg::state_e state_q, state_d;

  logic [KW-1:0]   wcount_q;
  logic [CW-1:0]   count_q, count_d;
  logic [LW-1:0]   total_q, total_d;
  logic [CW-1:0]   emit_q, emit_d;
  logic [GW-1:0]   scan_q, scan_d;
  logic            rvalid_q, rvalid_d;
  logic [GW-1:0]   ridx_q, ridx_d;
  logic            best_found_q, best_found_d;
  logic [GW-1:0]   best_g_q, best_g_d;
  logic [SW-1:0]   best_size_q, best_size_d;
  logic [WW-1:0]   wk_q, wk_d;
  logic [WW-1:0]   best_w_q, best_w_d;
  logic [LW-1:0]   best_load_q, best_load_d;
  logic [LW-1:0]   max_q, max_d;
  logic [AW-1:0]   active_q, active_d;
  logic [LW-1:0]   loads_q [lfgta_pkg::MaxWorkers];
  logic [LW-1:0]   loads_d [lfgta_pkg::MaxWorkers];
  logic            out_valid_q, out_valid_d;
  lfgta_pkg::out_t out_q, out_d;

  logic                      ram_we;
  logic [GW-1:0]             ram_waddr;
  logic [lfgta_pkg::RamW-1:0] ram_wdata;
  logic [lfgta_pkg::RamW-1:0] ram_rdata;

  logic [KW-1:0]   weff;
  logic            wk_last;
  logic            out_free;
  logic            in_fire;
  logic [LW:0]     total_sum;
  logic [LW:0]     load_sum;
  logic [LW-1:0]   new_load;
  logic [LW-1:0]   cand_load;
  logic [LW+1:0]   max_x2;
  logic [LW+1:0]   act_x3;
  logic            worthwhile;

  lfgta_ram #(
    .Width(lfgta_pkg::RamW),
    .Depth(lfgta_pkg::MaxGroups)
  ) u_size_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(scan_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    if (wcount_q == '0) begin
      weff = KW'(1);
    end else if (wcount_q > KW'(lfgta_pkg::MaxWorkers)) begin
      weff = KW'(lfgta_pkg::MaxWorkers);
    end else begin
      weff = wcount_q;
    end
  end

  assign wk_last    = (KW'(wk_q) == weff - KW'(1));
  assign in_stall_o = (state_q != lfgta_pkg::StLoad);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign total_sum  = {1'b0, total_q} + (LW+1)'(in_data_i.group_size);
  assign load_sum   = {1'b0, best_load_q} + (LW+1)'(best_size_q);
  assign new_load   = load_sum[LW] ? '1 : load_sum[LW-1:0];
  assign cand_load  = loads_q[wk_q];
  assign max_x2     = (LW+2)'(max_q) * (LW+2)'(lfgta_pkg::BalanceMul);
  assign act_x3     = (LW+2)'(active_q) * (LW+2)'(lfgta_pkg::WorkMul);
  assign worthwhile = (max_x2 <= (LW+2)'(total_q)) && (active_q != '0) &&
                      ((LW+2)'(total_q) >= act_x3);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    total_d      = total_q;
    emit_d       = emit_q;
    scan_d       = scan_q;
    rvalid_d     = 1'b0;
    ridx_d       = scan_q;
    best_found_d = best_found_q;
    best_g_d     = best_g_q;
    best_size_d  = best_size_q;
    wk_d         = wk_q;
    best_w_d     = best_w_q;
    best_load_d  = best_load_q;
    max_d        = max_q;
    active_d     = active_q;
    loads_d      = loads_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    ram_we       = 1'b0;
    ram_waddr    = best_g_q;
    ram_wdata    = {1'b1, best_size_q};

    // candidate from the size scan
    if (rvalid_q && !ram_rdata[SW] &&
        (!best_found_q || ram_rdata[SW-1:0] > best_size_q)) begin
      best_found_d = 1'b1;
      best_g_d     = ridx_q;
      best_size_d  = ram_rdata[SW-1:0];
    end

    case (state_q)
      lfgta_pkg::StLoad: begin
        if (in_fire) begin
          if (count_q < CW'(lfgta_pkg::MaxGroups)) begin
            ram_we    = 1'b1;
            ram_waddr = count_q[GW-1:0];
            ram_wdata = {1'b0, in_data_i.group_size};
            count_d   = count_q + CW'(1);
            total_d   = total_sum[LW] ? '1 : total_sum[LW-1:0];
          end
          if (in_data_i.final_group) begin
            state_d      = lfgta_pkg::StScan;
            scan_d       = '0;
            emit_d       = '0;
            best_found_d = 1'b0;
          end
        end
      end
      lfgta_pkg::StScan: begin
        rvalid_d = 1'b1;
        ridx_d   = scan_q;
        if (CW'(scan_q) == count_q - CW'(1)) begin
          state_d = lfgta_pkg::StDrain;
        end else begin
          scan_d = scan_q + GW'(1);
        end
      end
      lfgta_pkg::StDrain: begin
        state_d = lfgta_pkg::StWork;
        wk_d    = '0;
      end
      lfgta_pkg::StWork: begin
        if (wk_q == '0 || cand_load < best_load_q) begin
          best_w_d    = wk_q;
          best_load_d = cand_load;
        end
        if (wk_last) begin
          state_d = lfgta_pkg::StEmit;
        end else begin
          wk_d = wk_q + WW'(1);
        end
      end
      lfgta_pkg::StEmit: begin
        if (out_free) begin
          ram_we            = 1'b1;
          loads_d[best_w_q] = new_load;
          best_load_d       = new_load;
          emit_d            = emit_q + CW'(1);
          if (emit_q + CW'(1) == count_q) begin
            state_d  = lfgta_pkg::StCheck;
            wk_d     = '0;
            max_d    = '0;
            active_d = '0;
          end else begin
            out_valid_d                   = 1'b1;
            out_d.group_index             = best_g_q;
            out_d.worker_index            = best_w_q;
            out_d.worker_load_after       = new_load;
            out_d.parallel_worthwhile     = 1'b0;
            out_d.final_result            = 1'b0;
            state_d                       = lfgta_pkg::StScan;
            scan_d                        = '0;
            best_found_d                  = 1'b0;
          end
        end
      end
      lfgta_pkg::StCheck: begin
        if (cand_load > max_q) begin
          max_d = cand_load;
        end
        if (cand_load != '0) begin
          active_d = active_q + AW'(1);
        end
        if (wk_last) begin
          state_d = lfgta_pkg::StLast;
        end else begin
          wk_d = wk_q + WW'(1);
        end
      end
      lfgta_pkg::StLast: begin
        if (out_free) begin
          out_valid_d               = 1'b1;
          out_d.group_index         = best_g_q;
          out_d.worker_index        = best_w_q;
          out_d.worker_load_after   = best_load_q;
          out_d.parallel_worthwhile = worthwhile;
          out_d.final_result        = 1'b1;
          count_d                   = '0;
          total_d                   = '0;
          for (int i = 0; i < int'(lfgta_pkg::MaxWorkers); i++) begin
            loads_d[i] = '0;
          end
          state_d = lfgta_pkg::StLoad;
        end
      end
      default: begin
        state_d = lfgta_pkg::StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lfgta_pkg::StLoad;
      wcount_q     <= KW'(1);
      count_q      <= '0;
      total_q      <= '0;
      emit_q       <= '0;
      scan_q       <= '0;
      rvalid_q     <= 1'b0;
      best_found_q <= 1'b0;
      wk_q         <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < int'(lfgta_pkg::MaxWorkers); i++) begin
        loads_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) begin
        wcount_q <= cfg_wdata_i;
      end
      count_q      <= count_d;
      total_q      <= total_d;
      emit_q       <= emit_d;
      scan_q       <= scan_d;
      rvalid_q     <= rvalid_d;
      best_found_q <= best_found_d;
      wk_q         <= wk_d;
      out_valid_q  <= out_valid_d;
      loads_q      <= loads_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q      <= ridx_d;
    best_g_q    <= best_g_d;
    best_size_q <= best_size_d;
    best_w_q    <= best_w_d;
    best_load_q <= best_load_d;
    max_q       <= max_d;
    active_q    <= active_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LFGTA_ASSERT_NOW(a_scan_within_set, (state_q == lfgta_pkg::StScan), (emit_q < count_q), "scan with no cluster left")
  `LFGTA_ASSERT_NOW(a_emit_has_pick, (state_q == lfgta_pkg::StEmit), (best_found_q && (CW'(best_g_q) < count_q)), "emit without a valid pick")
  `LFGTA_ASSERT_NEXT(a_set_cleared, ((state_q == lfgta_pkg::StLast) && out_free), ((state_q == lfgta_pkg::StLoad) && (count_q == '0) && (total_q == '0)), "set state not cleared after last transaction")
  `LFGTA_ASSERT_NOW(a_flag_on_final, (out_valid_o && out_data_o.parallel_worthwhile), out_data_o.final_result, "worthwhile flag on a non-final transaction")

endmodule

`default_nettype wire
